@@ src/fcct_pkg.sv @@
// Shared constants and types of the cluster chain table.
`timescale 1ns / 1ps

package fcct_pkg;

	localparam int TABLE_DEPTH = 4096;
	localparam int IDX_W       = $clog2(TABLE_DEPTH);
	localparam int CNT_W       = IDX_W + 1;

	localparam logic [2:0] TAG_UNUSED = 3'd0;
	localparam logic [2:0] TAG_LINK   = 3'd1;
	localparam logic [2:0] TAG_END    = 3'd2;
	localparam logic [2:0] TAG_DIR    = 3'd3;
	localparam logic [2:0] TAG_BAD    = 3'd4;

	localparam logic [1:0] ST_OK      = 2'd0;
	localparam logic [1:0] ST_NOSPACE = 2'd1;
	localparam logic [1:0] ST_BADREQ  = 2'd2;
	localparam logic [1:0] ST_BROKEN  = 2'd3;

	localparam logic [2:0] KIND_WRITE      = 3'd0;
	localparam logic [2:0] KIND_READ       = 3'd1;
	localparam logic [2:0] KIND_ALLOC_DIR  = 3'd2;
	localparam logic [2:0] KIND_ALLOC_FILE = 3'd3;
	localparam logic [2:0] KIND_FREE_CHAIN = 3'd4;
	localparam logic [2:0] KIND_RELOCATE   = 3'd5;

	typedef struct packed {
		logic [2:0]       tag;
		logic [IDX_W-1:0] next;
	} entry_t;

endpackage

@@ src/fat_cluster_chain_table.sv @@
// Cluster chain table: allocation table memory with its request sequencer.
`timescale 1ns / 1ps

// A request is taken at a rising edge with start high and busy low. Its one
// result appears on status, cluster_out, entry_tag_out and entry_next_out for
// exactly one cycle, marked by done; the receiver cannot stall, so nothing is
// held back. The block serves one request at a time and raises busy until it
// has finished it.
// The table lives in one synchronous memory with a separate write port and a
// registered read port, so a step that needs an entry reads it, looks at it
// in the next cycle and writes any change back through the write port.
// A free cluster scan issues one read per cycle; allocating a file scans twice
// (count, then chain). Freeing a chain walks it twice, and every step of the
// walk waits on the dependent memory read of the link before it.
// After reset the block sweeps the memory and sets every entry unused, one
// entry a cycle; busy stays high until the sweep is over.
// clusters_in_use may be written with cfg_we at any time the block is idle.
module fat_cluster_chain_table (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      cfg_we,
	input  logic [fcct_pkg::CNT_W-1:0] clusters_in_use,
	input  logic                      start,
	output logic                      busy,
	input  logic [2:0]                kind,
	input  logic [fcct_pkg::IDX_W-1:0] base_cluster,
	input  logic [fcct_pkg::IDX_W-1:0] prev_cluster,
	input  logic                      has_prev,
	input  logic [fcct_pkg::CNT_W-1:0] clusters_needed,
	input  logic                      is_directory,
	input  logic [2:0]                entry_tag_in,
	input  logic [fcct_pkg::IDX_W-1:0] entry_next_in,
	output logic                      done,
	output logic [1:0]                status,
	output logic [fcct_pkg::IDX_W-1:0] cluster_out,
	output logic [2:0]                entry_tag_out,
	output logic [fcct_pkg::IDX_W-1:0] entry_next_out
);
	import fcct_pkg::*;

	typedef enum logic [3:0] {
		S_CLEAR, S_IDLE, S_RD_WAIT, S_DIR_SCAN, S_CNT_SCAN, S_FILE_SCAN, S_FILE_END,
		S_WALK_RD, S_WALK_CHK, S_FREE_RD, S_FREE_WR, S_REL_CAP, S_REL_SCAN,
		S_REL_PREV, S_REL_BAD
	} state_t;

	localparam logic [CNT_W-1:0] DEPTH_C = CNT_W'(TABLE_DEPTH);

	state_t state_q;

	// Table memory.
	entry_t mem_q [TABLE_DEPTH];
	entry_t rd_data_q;
	logic [IDX_W-1:0] rd_addr;
	logic             wr_en_q;
	logic [IDX_W-1:0] wr_addr_q;
	entry_t           wr_data_q;

	// Configuration and request registers.
	logic [CNT_W-1:0] cfg_q;
	logic [CNT_W-1:0] lim;
	logic [IDX_W-1:0] start_q, prev_q;
	logic             has_prev_q;
	logic [CNT_W-1:0] needed_q;
	logic [2:0]       term_q;

	// Scan, walk and allocation bookkeeping.
	logic [CNT_W-1:0] clr_q;
	logic [CNT_W-1:0] scan_addr_q;
	logic             chk_vld_s1;
	logic [IDX_W-1:0] chk_addr_s1;
	logic [IDX_W-1:0] skip_q;
	logic [CNT_W-1:0] cnt_q;
	logic [IDX_W-1:0] cur_q, first_q, last_q;
	logic             have_last_q;
	entry_t           ent_q;

	// Result registers.
	logic             done_q;
	logic [1:0]       status_q;
	logic [IDX_W-1:0] cluster_q;
	logic [2:0]       tag_out_q;
	logic [IDX_W-1:0] next_out_q;

	logic accept, hit, can_issue, scan_end;
	logic [CNT_W-1:0] cnt_inc;

	// A pending write must land before the next request reads the table.
	assign busy   = (state_q != S_IDLE) || wr_en_q;
	assign accept = start && !busy;
	assign lim    = (cfg_q > DEPTH_C) ? DEPTH_C : cfg_q;

	// The scan checks the entry read in the cycle before: unused, and not the skipped address.
	assign hit       = chk_vld_s1 && (rd_data_q.tag == TAG_UNUSED) && (chk_addr_s1 != skip_q);
	assign can_issue = scan_addr_q < lim;
	assign scan_end  = !hit && !chk_vld_s1 && !can_issue;
	assign cnt_inc   = cnt_q + CNT_W'(1);

	always_comb begin
		case (state_q)
			S_IDLE:                                         rd_addr = base_cluster;
			S_DIR_SCAN, S_CNT_SCAN, S_FILE_SCAN, S_REL_SCAN: rd_addr = scan_addr_q[IDX_W-1:0];
			default:                                        rd_addr = cur_q;
		endcase
	end

	always_ff @(posedge clk) begin
		if (wr_en_q) begin
			mem_q[wr_addr_q] <= wr_data_q;
		end
		rd_data_q <= mem_q[rd_addr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_CLEAR;
			cfg_q       <= DEPTH_C;
			clr_q       <= '0;
			wr_en_q     <= 1'b0;
			done_q      <= 1'b0;
			chk_vld_s1  <= 1'b0;
			have_last_q <= 1'b0;
		end else begin
			done_q  <= 1'b0;
			wr_en_q <= 1'b0;
			if (cfg_we) begin
				cfg_q <= clusters_in_use;
			end

			// Scan pipeline advances by default; stopping states override it.
			if (state_q == S_DIR_SCAN || state_q == S_CNT_SCAN ||
			    state_q == S_FILE_SCAN || state_q == S_REL_SCAN) begin
				chk_vld_s1  <= can_issue;
				chk_addr_s1 <= scan_addr_q[IDX_W-1:0];
				if (can_issue) begin
					scan_addr_q <= scan_addr_q + CNT_W'(1);
				end
			end

			case (state_q)
				S_CLEAR: begin
					if (clr_q[IDX_W]) begin
						state_q <= S_IDLE;
					end else begin
						wr_en_q   <= 1'b1;
						wr_addr_q <= clr_q[IDX_W-1:0];
						wr_data_q <= '0;
						clr_q     <= clr_q + CNT_W'(1);
					end
				end

				S_IDLE: begin
					if (accept) begin
						start_q     <= base_cluster;
						prev_q      <= prev_cluster;
						has_prev_q  <= has_prev;
						needed_q    <= clusters_needed;
						term_q      <= is_directory ? TAG_DIR : TAG_END;
						status_q    <= ST_OK;
						cluster_q   <= '0;
						tag_out_q   <= '0;
						next_out_q  <= '0;
						scan_addr_q <= CNT_W'(1);
						chk_vld_s1  <= 1'b0;
						skip_q      <= '0;
						cnt_q       <= '0;
						cur_q       <= base_cluster;
						case (kind)
							KIND_WRITE: begin
								done_q <= 1'b1;
								if (CNT_W'(base_cluster) >= lim || entry_tag_in > TAG_BAD) begin
									status_q <= ST_BADREQ;
								end else begin
									wr_en_q        <= 1'b1;
									wr_addr_q      <= base_cluster;
									wr_data_q.tag  <= entry_tag_in;
									wr_data_q.next <= (entry_tag_in == TAG_LINK) ? entry_next_in : '0;
								end
							end
							KIND_READ: begin
								if (CNT_W'(base_cluster) >= lim) begin
									status_q <= ST_BADREQ;
									done_q   <= 1'b1;
								end else begin
									state_q <= S_RD_WAIT;
								end
							end
							KIND_ALLOC_DIR: begin
								state_q <= S_DIR_SCAN;
							end
							KIND_ALLOC_FILE: begin
								if (clusters_needed == '0) begin
									status_q <= ST_BADREQ;
									done_q   <= 1'b1;
								end else begin
									state_q <= S_CNT_SCAN;
								end
							end
							KIND_FREE_CHAIN: begin
								if (CNT_W'(base_cluster) >= lim) begin
									status_q <= ST_BADREQ;
									done_q   <= 1'b1;
								end else begin
									state_q <= S_WALK_RD;
								end
							end
							KIND_RELOCATE: begin
								if (CNT_W'(base_cluster) >= lim ||
								    (has_prev && CNT_W'(prev_cluster) >= lim)) begin
									status_q <= ST_BADREQ;
									done_q   <= 1'b1;
								end else begin
									skip_q  <= base_cluster;
									state_q <= S_REL_CAP;
								end
							end
							default: begin
								status_q <= ST_BADREQ;
								done_q   <= 1'b1;
							end
						endcase
					end
				end

				S_RD_WAIT: begin
					tag_out_q  <= rd_data_q.tag;
					next_out_q <= rd_data_q.next;
					done_q     <= 1'b1;
					state_q    <= S_IDLE;
				end

				S_DIR_SCAN: begin
					if (hit) begin
						wr_en_q    <= 1'b1;
						wr_addr_q  <= chk_addr_s1;
						wr_data_q  <= '{tag: TAG_DIR, next: '0};
						cluster_q  <= chk_addr_s1;
						chk_vld_s1 <= 1'b0;
						done_q     <= 1'b1;
						state_q    <= S_IDLE;
					end else if (scan_end) begin
						status_q <= ST_NOSPACE;
						done_q   <= 1'b1;
						state_q  <= S_IDLE;
					end
				end

				// First pass only counts, so a short table changes nothing.
				S_CNT_SCAN: begin
					if (hit) begin
						cnt_q <= cnt_inc;
						if (cnt_inc == needed_q) begin
							cnt_q       <= '0;
							scan_addr_q <= CNT_W'(1);
							chk_vld_s1  <= 1'b0;
							have_last_q <= 1'b0;
							state_q     <= S_FILE_SCAN;
						end
					end else if (scan_end) begin
						status_q <= ST_NOSPACE;
						done_q   <= 1'b1;
						state_q  <= S_IDLE;
					end
				end

				// Each link is written into the entry found before and points forward to the one just found.
				S_FILE_SCAN: begin
					if (hit) begin
						if (have_last_q) begin
							wr_en_q   <= 1'b1;
							wr_addr_q <= last_q;
							wr_data_q <= '{tag: TAG_LINK, next: chk_addr_s1};
						end else begin
							first_q <= chk_addr_s1;
						end
						last_q      <= chk_addr_s1;
						have_last_q <= 1'b1;
						cnt_q       <= cnt_inc;
						if (cnt_inc == needed_q) begin
							chk_vld_s1 <= 1'b0;
							state_q    <= S_FILE_END;
						end
					end else if (scan_end) begin
						state_q <= S_FILE_END;
					end
				end

				S_FILE_END: begin
					wr_en_q   <= 1'b1;
					wr_addr_q <= last_q;
					wr_data_q <= '{tag: TAG_END, next: '0};
					cluster_q <= first_q;
					done_q    <= 1'b1;
					state_q   <= S_IDLE;
				end

				// The whole chain is checked before any entry is freed.
				S_WALK_RD: begin
					if (cnt_q >= lim) begin
						status_q <= ST_BROKEN;
						done_q   <= 1'b1;
						state_q  <= S_IDLE;
					end else begin
						state_q <= S_WALK_CHK;
					end
				end

				S_WALK_CHK: begin
					if (rd_data_q.tag == term_q) begin
						cur_q   <= start_q;
						state_q <= S_FREE_RD;
					end else if (rd_data_q.tag != TAG_LINK || CNT_W'(rd_data_q.next) >= lim) begin
						status_q <= ST_BROKEN;
						done_q   <= 1'b1;
						state_q  <= S_IDLE;
					end else begin
						cur_q   <= rd_data_q.next;
						cnt_q   <= cnt_inc;
						state_q <= S_WALK_RD;
					end
				end

				S_FREE_RD: begin
					state_q <= S_FREE_WR;
				end

				S_FREE_WR: begin
					wr_en_q   <= 1'b1;
					wr_addr_q <= cur_q;
					wr_data_q <= '0;
					if (rd_data_q.tag == term_q) begin
						done_q  <= 1'b1;
						state_q <= S_IDLE;
					end else begin
						cur_q   <= rd_data_q.next;
						state_q <= S_FREE_RD;
					end
				end

				S_REL_CAP: begin
					ent_q   <= rd_data_q;
					state_q <= S_REL_SCAN;
				end

				S_REL_SCAN: begin
					if (hit) begin
						wr_en_q        <= 1'b1;
						wr_addr_q      <= chk_addr_s1;
						wr_data_q.tag  <= ent_q.tag;
						wr_data_q.next <= (ent_q.tag == TAG_LINK) ? ent_q.next : '0;
						cluster_q      <= chk_addr_s1;
						chk_vld_s1     <= 1'b0;
						state_q        <= has_prev_q ? S_REL_PREV : S_REL_BAD;
					end else if (scan_end) begin
						status_q <= ST_NOSPACE;
						done_q   <= 1'b1;
						state_q  <= S_IDLE;
					end
				end

				S_REL_PREV: begin
					wr_en_q   <= 1'b1;
					wr_addr_q <= prev_q;
					wr_data_q <= '{tag: TAG_LINK, next: cluster_q};
					state_q   <= S_REL_BAD;
				end

				S_REL_BAD: begin
					wr_en_q   <= 1'b1;
					wr_addr_q <= start_q;
					wr_data_q <= '{tag: TAG_BAD, next: '0};
					done_q    <= 1'b1;
					state_q   <= S_IDLE;
				end

				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign done           = done_q;
	assign status         = status_q;
	assign cluster_out    = cluster_q;
	assign entry_tag_out  = tag_out_q;
	assign entry_next_out = next_out_q;

	// An accepted request either finishes at once or keeps the block busy.
	a_accept_progress: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> (done || busy)) else $error("request dropped after acceptance");

	// A result only follows a request or work in progress.
	a_no_invented: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(start || busy)) else $error("result without a request");

	// No result may come out of the clearing sweep.
	a_clear_quiet: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_CLEAR) |-> !done) else $error("result during clearing sweep");

	// A failed request reports no cluster.
	a_nospace_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(done && status != ST_OK) |-> (cluster_out == '0)) else $error("cluster on failure");

endmodule

@@ tb/tb_top.sv @@
// Self-checking testbench of the cluster chain table.
`timescale 1ns / 1ps

module tb_top;
	import fcct_pkg::*;

	// One request as the block takes it, and the one result that it answers.
	typedef struct {
		logic [2:0]  kind;
		logic [11:0] start_cl;
		logic [11:0] prev_cl;
		logic        has_prev;
		logic [12:0] needed;
		logic        is_dir;
		logic [2:0]  tag;
		logic [11:0] next;
	} request_t;

	typedef struct {
		logic [1:0]  status;
		logic [11:0] cl;
		logic [2:0]  tag;
		logic [11:0] next;
	} outcome_t;

	// A chain head that the stimulus knows about, with the mark that ends its chain.
	typedef struct {
		int idx;
		bit dir;
	} chain_head_t;

	// The scoreboard keeps its own copy of the allocation table. Each accepted
	// request is applied to that copy at once, which is exact because the block
	// serves requests strictly one at a time.
	class alloc_table_board;
		logic [2:0]  tags [TABLE_DEPTH];
		logic [11:0] links[TABLE_DEPTH];
		int          usable;
		outcome_t    expected_outcomes[$];
		chain_head_t heads[$];
		int          mismatches;
		logic [11:0] last_cl;

		function new();
			for (int i = 0; i < TABLE_DEPTH; i++) begin
				tags[i]  = TAG_UNUSED;
				links[i] = '0;
			end
			usable     = TABLE_DEPTH;
			mismatches = 0;
		endfunction

		function void set_limit(int v);
			usable = (v > TABLE_DEPTH) ? TABLE_DEPTH : v;
		endfunction

		function void put_entry(int idx, logic [2:0] t, logic [11:0] nx);
			tags[idx]  = t;
			links[idx] = (t == TAG_LINK) ? nx : 12'd0;
		endfunction

		function int find_free(int skip);
			for (int i = 1; i < usable; i++)
				if (tags[i] == TAG_UNUSED && i != skip)
					return i;
			return usable;
		endfunction

		function void drop_head(int idx);
			foreach (heads[i])
				if (heads[i].idx == idx) begin
					heads.delete(i);
					return;
				end
		endfunction

		// Applies one request to the table copy and returns its result.
		function outcome_t predict_outcome(request_t r);
			outcome_t    o;
			chain_head_t h;
			int          lim, i, cnt, cur, first, last, nx;
			logic [2:0]  term, t;
			bit          ok;
			lim = usable;
			o   = '{ST_OK, 12'd0, 3'd0, 12'd0};
			case (r.kind)
				KIND_WRITE: begin
					if (r.start_cl >= lim || r.tag > TAG_BAD)
						o.status = ST_BADREQ;
					else
						put_entry(int'(r.start_cl), r.tag, r.next);
				end
				KIND_READ: begin
					if (r.start_cl >= lim) begin
						o.status = ST_BADREQ;
					end else begin
						o.tag  = tags[r.start_cl];
						o.next = links[r.start_cl];
					end
				end
				KIND_ALLOC_DIR: begin
					i = find_free(0);
					if (i >= lim) begin
						o.status = ST_NOSPACE;
					end else begin
						put_entry(i, TAG_DIR, 12'd0);
						o.cl  = 12'(i);
						h.idx = i;
						h.dir = 1'b1;
						heads = {heads, h};
					end
				end
				KIND_ALLOC_FILE: begin
					if (r.needed == 0) begin
						o.status = ST_BADREQ;
					end else begin
						cnt = 0;
						for (i = 1; i < lim && cnt < r.needed; i++)
							if (tags[i] == TAG_UNUSED)
								cnt++;
						if (cnt < r.needed) begin
							o.status = ST_NOSPACE;
						end else begin
							// Chain the free clusters in ascending order, then close it.
							first = lim;
							last  = lim;
							cnt   = 0;
							for (i = 1; i < lim && cnt < r.needed; i++) begin
								if (tags[i] == TAG_UNUSED) begin
									if (last < lim)
										put_entry(last, TAG_LINK, 12'(i));
									else
										first = i;
									last = i;
									cnt++;
								end
							end
							put_entry(last, TAG_END, 12'd0);
							o.cl  = 12'(first);
							h.idx = first;
							h.dir = 1'b0;
							heads = {heads, h};
						end
					end
				end
				KIND_FREE_CHAIN: begin
					term = r.is_dir ? TAG_DIR : TAG_END;
					if (r.start_cl >= lim) begin
						o.status = ST_BADREQ;
					end else begin
						// The whole walk is checked before anything is freed.
						ok  = 0;
						cur = int'(r.start_cl);
						for (cnt = 0; cnt < lim; cnt++) begin
							if (tags[cur] == term) begin
								ok = 1;
								break;
							end
							if (tags[cur] != TAG_LINK || links[cur] >= lim)
								break;
							cur = int'(links[cur]);
						end
						if (!ok) begin
							o.status = ST_BROKEN;
						end else begin
							cur = int'(r.start_cl);
							forever begin
								t  = tags[cur];
								nx = int'(links[cur]);
								put_entry(cur, TAG_UNUSED, 12'd0);
								if (t == term)
									break;
								cur = nx;
							end
							drop_head(int'(r.start_cl));
						end
					end
				end
				KIND_RELOCATE: begin
					if (r.start_cl >= lim || (r.has_prev && r.prev_cl >= lim)) begin
						o.status = ST_BADREQ;
					end else begin
						i = find_free(int'(r.start_cl));
						if (i >= lim) begin
							o.status = ST_NOSPACE;
						end else begin
							put_entry(i, tags[r.start_cl], links[r.start_cl]);
							if (r.has_prev)
								put_entry(int'(r.prev_cl), TAG_LINK, 12'(i));
							put_entry(int'(r.start_cl), TAG_BAD, 12'd0);
							o.cl = 12'(i);
							// A moved head keeps its chain under the new index.
							foreach (heads[j])
								if (heads[j].idx == int'(r.start_cl))
									heads[j].idx = i;
						end
					end
				end
				default: o.status = ST_BADREQ;
			endcase
			return o;
		endfunction

		function void note_request(request_t r);
			outcome_t o;
			o                 = predict_outcome(r);
			last_cl           = o.cl;
			expected_outcomes = {expected_outcomes, o};
		endfunction

		task report_mismatch(string what, int got, int want);
			$display("%0t mismatch: %s got %0d expected %0d", $realtime, what, got, want);
			mismatches++;
		endtask

		task check_result(logic [1:0] st, logic [11:0] cl, logic [2:0] tg, logic [11:0] nx);
			outcome_t o;
			if (expected_outcomes.size() == 0) begin
				report_mismatch("result with no request pending", int'(st), 0);
			end else begin
				o = expected_outcomes[0];
				expected_outcomes.delete(0);
				if (st !== o.status) report_mismatch("status", int'(st), int'(o.status));
				if (cl !== o.cl)     report_mismatch("cluster_out", int'(cl), int'(o.cl));
				if (tg !== o.tag)    report_mismatch("entry_tag_out", int'(tg), int'(o.tag));
				if (nx !== o.next)   report_mismatch("entry_next_out", int'(nx), int'(o.next));
			end
		endtask
	endclass

	// Allocating a file at full size scans the table twice and freeing a long or
	// looped chain walks it twice, so the ceiling is several times the slowest mix
	// of requests plus the clearing sweep after reset.
	localparam int CYCLE_LIMIT = 12000000;
	localparam int SETTLE      = 40;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        cfg_we = 1'b0;
	logic [12:0] clusters_in_use = 13'd4096;
	logic        start = 1'b0;
	logic        busy;
	logic [2:0]  kind = '0;
	logic [11:0] base_cluster = '0;
	logic [11:0] prev_cluster = '0;
	logic        has_prev = 1'b0;
	logic [12:0] clusters_needed = '0;
	logic        is_directory = 1'b0;
	logic [2:0]  entry_tag_in = '0;
	logic [11:0] entry_next_in = '0;
	logic        done;
	logic [1:0]  status;
	logic [11:0] cluster_out;
	logic [2:0]  entry_tag_out;
	logic [11:0] entry_next_out;

	alloc_table_board board = new();
	int               cycles = 0;
	int               idle_pct = 6;

	fat_cluster_chain_table dut (
		.clk(clk), .arst_n(arst_n), .cfg_we(cfg_we), .clusters_in_use(clusters_in_use),
		.start(start), .busy(busy), .kind(kind), .base_cluster(base_cluster),
		.prev_cluster(prev_cluster), .has_prev(has_prev), .clusters_needed(clusters_needed),
		.is_directory(is_directory), .entry_tag_in(entry_tag_in),
		.entry_next_in(entry_next_in), .done(done), .status(status),
		.cluster_out(cluster_out), .entry_tag_out(entry_tag_out),
		.entry_next_out(entry_next_out)
	);

	always #5 clk = ~clk;

	// Watchdog: a hung handshake or a lost result ends the run here.
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("Regression FAIL");
			$finish;
		end
	end

	// The result ports are read at the edge that closes the done cycle; the
	// values seen here are the ones from before that edge.
	always @(posedge clk) begin
		if (arst_n && done)
			board.check_result(status, cluster_out, entry_tag_out, entry_next_out);
	end

	// Presents one request and holds it until an edge finds busy low. Start is
	// left high but for a random idle gap, so a next request has no bubble.
	task send_request(request_t r);
		kind            <= r.kind;
		base_cluster    <= r.start_cl;
		prev_cluster    <= r.prev_cl;
		has_prev        <= r.has_prev;
		clusters_needed <= r.needed;
		is_directory    <= r.is_dir;
		entry_tag_in    <= r.tag;
		entry_next_in   <= r.next;
		start           <= 1'b1;
		do @(posedge clk); while (busy);
		board.note_request(r);
		if ($urandom_range(0, 99) < idle_pct) begin
			start <= 1'b0;
			repeat ($urandom_range(1, 5)) @(posedge clk);
		end
	endtask

	task issue(logic [2:0] k, int st, int pv, bit hp, int nd, bit dr, int tg, int nx);
		request_t r;
		r = '{k, 12'(st), 12'(pv), hp, 13'(nd), dr, 3'(tg), 12'(nx)};
		send_request(r);
	endtask

	// Waits out every pending result and busy, then lets the bench settle.
	task drain();
		start <= 1'b0;
		@(posedge clk);
		while (board.expected_outcomes.size() != 0 || busy)
			@(posedge clk);
		repeat (SETTLE) @(posedge clk);
	endtask

	task write_limit(int v);
		while (busy) @(posedge clk);
		cfg_we          <= 1'b1;
		clusters_in_use <= 13'(v);
		@(posedge clk);
		board.set_limit(v);
		cfg_we <= 1'b0;
	endtask

	// Random request with random content in every field. Part of the stream
	// works on chains that the table really holds, so walks, moves and frees
	// get past their first checks; allocations, reads, writes and noise make up the rest.
	function request_t random_request();
		request_t    r;
		int          pick, steps, cur, lim;
		chain_head_t h;
		lim = board.usable;
		r.kind     = 3'($urandom_range(0, 5));
		r.start_cl = 12'($urandom_range(0, lim - 1));
		r.prev_cl  = 12'($urandom_range(0, lim - 1));
		r.has_prev = 1'($urandom_range(0, 1));
		r.needed   = 13'($urandom_range(1, (lim > 8) ? lim / 4 : 2));
		r.is_dir   = 1'($urandom_range(0, 1));
		r.tag      = 3'($urandom_range(0, 4));
		r.next     = 12'($urandom_range(0, lim - 1));
		pick       = $urandom_range(0, 99);
		if (pick < 16) begin
			r.kind = KIND_ALLOC_FILE;
		end else if (pick < 28) begin
			r.kind = KIND_ALLOC_DIR;
		end else if (pick < 62 && board.heads.size() != 0) begin
			h = board.heads[$urandom_range(0, board.heads.size() - 1)];
			if (pick < 46) begin
				r.kind     = KIND_FREE_CHAIN;
				r.start_cl = 12'(h.idx);
				r.is_dir   = ($urandom_range(0, 99) < 85) ? h.dir : !h.dir;
			end else begin
				// Move some link of a known chain, naming its true predecessor.
				r.kind     = KIND_RELOCATE;
				cur        = h.idx;
				r.has_prev = 1'b0;
				steps      = $urandom_range(0, 3);
				while (steps > 0 && board.tags[cur] == TAG_LINK && board.links[cur] < lim) begin
					r.prev_cl  = 12'(cur);
					r.has_prev = 1'b1;
					cur        = int'(board.links[cur]);
					steps--;
				end
				r.start_cl = 12'(cur);
			end
		end else if (pick < 74) begin
			r.kind = KIND_READ;
		end else if (pick < 84) begin
			r.kind = KIND_WRITE;
		end else begin
			// Noise: any field value at all, unknown kinds and out-of-range indexes.
			r.kind     = 3'($urandom_range(0, 7));
			r.start_cl = 12'($urandom_range(0, 4095));
			r.prev_cl  = 12'($urandom_range(0, 4095));
			r.needed   = 13'($urandom_range(0, 8191));
			r.tag      = 3'($urandom_range(0, 7));
			r.next     = 12'($urandom_range(0, 4095));
		end
		return r;
	endfunction

	task random_phase(int lim, int count, int pct);
		write_limit(lim);
		idle_pct = pct;
		repeat (count) send_request(random_request());
		drain();
	endtask

	initial begin
		int head, mid;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		// The clearing sweep after reset holds busy high; write_limit waits it out.
		write_limit(4096);

		// Directed part at the full table size.
		issue(KIND_READ, 0, 0, 0, 0, 0, 0, 0);
		issue(KIND_WRITE, 4095, 4095, 1, 8191, 1, TAG_BAD, 4095);
		issue(KIND_READ, 4095, 0, 0, 0, 0, 0, 0);
		issue(KIND_WRITE, 5, 0, 0, 0, 0, 5, 0);       // tag out of range
		issue(KIND_WRITE, 5, 0, 0, 0, 0, 7, 0);
		issue(KIND_WRITE, 4000, 0, 0, 0, 0, TAG_END, 4095); // next is dropped
		issue(KIND_READ, 4000, 0, 0, 0, 0, 0, 0);
		issue(3'd6, 0, 0, 0, 0, 0, 0, 0);             // unknown kinds
		issue(3'd7, 0, 0, 0, 0, 0, 0, 0);
		issue(KIND_ALLOC_DIR, 0, 0, 0, 0, 0, 0, 0);
		issue(KIND_ALLOC_FILE, 0, 0, 0, 0, 0, 0, 0);  // zero clusters
		issue(KIND_ALLOC_FILE, 0, 0, 0, 4096, 0, 0, 0); // more than exist
		issue(KIND_ALLOC_FILE, 0, 0, 0, 4, 0, 0, 0);
		head = int'(board.last_cl);
		mid  = int'(board.links[head]);
		issue(KIND_RELOCATE, mid, head, 1, 0, 0, 0, 0);   // move an inner link
		issue(KIND_RELOCATE, head, 0, 0, 0, 0, 0, 0);     // move the head itself
		head = int'(board.last_cl);
		issue(KIND_FREE_CHAIN, head, 0, 0, 0, 1, 0, 0);   // wrong terminator
		issue(KIND_FREE_CHAIN, head, 0, 0, 0, 0, 0, 0);
		issue(KIND_WRITE, 3000, 0, 0, 0, 0, TAG_LINK, 3000); // self loop
		issue(KIND_FREE_CHAIN, 3000, 0, 0, 0, 0, 0, 0);   // walk runs too long
		issue(KIND_WRITE, 3000, 0, 0, 0, 0, TAG_UNUSED, 0);
		drain();

		// Smallest table: one usable cluster, so the searches soon run dry.
		write_limit(2);
		issue(KIND_ALLOC_DIR, 0, 0, 0, 0, 0, 0, 0);
		issue(KIND_ALLOC_DIR, 0, 0, 0, 0, 0, 0, 0);
		issue(KIND_RELOCATE, 1, 0, 0, 0, 0, 0, 0);        // no free cluster
		issue(KIND_RELOCATE, 1, 3, 1, 0, 0, 0, 0);        // predecessor out of range
		issue(KIND_READ, 2, 0, 0, 0, 0, 0, 0);
		issue(KIND_FREE_CHAIN, 1, 0, 0, 0, 1, 0, 0);
		drain();

		// Random part, several table sizes, the sender's pacing changing over it.
		random_phase(16, 20, 6);
		random_phase(2, 6, 6);
		random_phase(64, 30, 49);
		random_phase(4096, 14, 49);
		random_phase(300, 44, 0);

		if (board.mismatches == 0) begin
			$display("Regression PASS");
		end else begin
			$display("Regression FAIL");
		end
		$finish;
	end

endmodule

@@ fat_cluster_chain_table.f @@
src/fcct_pkg.sv
src/fat_cluster_chain_table.sv
tb/tb_top.sv
